// File: sv/npt_pkg.sv
// Package for the nearest-pairs top-k list: command codes, entry type and cell control.
// Depends on nothing; the cell and the top-level module refer to it by scoped names.
package npt_pkg;

	// Command codes carried on the request channel.
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_OFFER = 2'd1;
	localparam logic [1:0] CMD_DUMP  = 2'd2;

	localparam int DIST_W = 32;
	localparam int ID_W   = 16;

	// Default number of list entries.
	localparam int LIST_DEPTH_DEF = 8;

	// Reset contents of a list entry.
	localparam logic [DIST_W-1:0] DIST_RESET = '1;

	typedef struct packed {
		logic [DIST_W-1:0] sq_dist;
		logic [ID_W-1:0]   first;
		logic [ID_W-1:0]   second;
	} entry_t;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_OFFER  = 2'd2,
		OP_ROTATE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   ins;
	} cell_ctrl_t;

endpackage

// File: sv/npt_if.sv
// Handshake interfaces of the nearest-pairs top-k list: request and response channels.
// Depends on nothing but the field widths fixed by the block's item format.
interface npt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] dist_sq;
	logic [15:0] first_id;
	logic [15:0] second_id;

	modport source(output valid, cmd, dist_sq, first_id, second_id, input ready);
	modport sink(input valid, cmd, dist_sq, first_id, second_id, output ready);
endinterface

interface npt_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_dist;
	logic [15:0] out_first;
	logic [15:0] out_second;
	logic        is_last;

	modport source(output valid, out_dist, out_first, out_second, is_last, input ready);
	modport sink(input valid, out_dist, out_first, out_second, is_last, output ready);
endinterface

// File: sv/npt_cell.sv
// One cell of the insertion chain: holds a single list entry and trades it with its neighbours.
// Depends on npt_pkg for the entry type and the broadcast control.
module npt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  npt_pkg::cell_ctrl_t ctrl,
	input  npt_pkg::entry_t    left,
	input  logic               left_gt,
	input  npt_pkg::entry_t    right,
	output npt_pkg::entry_t    entry,
	output logic               gt
);

	npt_pkg::entry_t entry_q;
	npt_pkg::entry_t entry_nxt;

	// The offered distance beats this entry when it is strictly smaller.
	assign gt    = ctrl.ins.sq_dist < entry_q.sq_dist;
	assign entry = entry_q;

	// An offer shifts larger entries back one place; the first of them takes the new pair.
	always_comb begin
		entry_nxt = entry_q;
		case (ctrl.op)
			npt_pkg::OP_CLEAR: begin
				entry_nxt.sq_dist = ctrl.ins.sq_dist;
				entry_nxt.first   = '0;
				entry_nxt.second  = '0;
			end
			npt_pkg::OP_OFFER: begin
				if (gt) begin
					entry_nxt = left_gt ? left : ctrl.ins;
				end
			end
			npt_pkg::OP_ROTATE: entry_nxt = right;
			default: entry_nxt = entry_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.sq_dist <= npt_pkg::DIST_RESET;
			entry_q.first   <= '0;
			entry_q.second  <= '0;
		end else begin
			entry_q <= entry_nxt;
		end
	end

endmodule

// File: sv/nearest_pairs_topk_list.sv
// A clear or an offer takes effect in the next cycle; one such beat is accepted every cycle
// while no dump rotates. An accepted dump sets the dump flag; each rotation step loads the
// output register, one beat per cycle while the sink is ready. The chain rotates once per beat,
// and requests wait until the final step. The last beat may wait in the output register while
// the next request is taken. Reset gives distances of all ones and zero ids in every entry.
module nearest_pairs_topk_list #(
	parameter int LIST_DEPTH = npt_pkg::LIST_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	npt_req_if.sink  req,
	npt_rsp_if.source rsp
);

	localparam int CNT_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIST_DEPTH - 1);

	npt_pkg::cell_ctrl_t ctrl;
	npt_pkg::entry_t     cell_entry [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] cell_gt;

	logic             dump_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	npt_pkg::entry_t  out_entry_q;
	logic             out_last_q;

	logic accept;
	logic step;

	// Requests are held off only while a dump is rotating through the chain.
	assign req.ready = !dump_q;
	assign accept    = req.valid && req.ready;
	assign step      = dump_q && (!out_valid_q || rsp.ready);

	// Broadcast control for the whole chain.
	always_comb begin
		ctrl.ins.sq_dist = req.dist_sq;
		ctrl.ins.first   = req.first_id;
		ctrl.ins.second  = req.second_id;
		ctrl.op          = npt_pkg::OP_HOLD;
		if (step) begin
			ctrl.op = npt_pkg::OP_ROTATE;
		end else if (accept && req.cmd == npt_pkg::CMD_CLEAR) begin
			ctrl.op = npt_pkg::OP_CLEAR;
		end else if (accept && req.cmd == npt_pkg::CMD_OFFER) begin
			ctrl.op = npt_pkg::OP_OFFER;
		end
	end

	// The chain of cells; the last cell takes the head's entry during rotation.
	for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
		npt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.left    (cell_entry[(k > 0) ? k - 1 : 0]),
			.left_gt ((k > 0) ? cell_gt[(k > 0) ? k - 1 : 0] : 1'b0),
			.right   (cell_entry[(k + 1) % LIST_DEPTH]),
			.entry   (cell_entry[k]),
			.gt      (cell_gt[k])
		);
	end

	// Dump sequencing: count beats while the chain rotates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dump_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (accept && req.cmd == npt_pkg::CMD_DUMP) begin
				dump_q <= 1'b1;
				cnt_q  <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					dump_q <= 1'b0;
				end
			end
		end
	end

	// Output register: takes the head of the chain on every rotation step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_entry_q <= cell_entry[0];
			out_last_q  <= (cnt_q == CNT_LAST);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_dist   = out_entry_q.sq_dist;
	assign rsp.out_first  = out_entry_q.first;
	assign rsp.out_second = out_entry_q.second;
	assign rsp.is_last    = out_last_q;

	// Order check over neighbouring cells and a packed view of the distances.
	logic                     sorted;
	logic [LIST_DEPTH-1:0][31:0] dist_vec;

	always_comb begin
		sorted = 1'b1;
		for (int k = 0; k < LIST_DEPTH; k++) begin
			dist_vec[k] = cell_entry[k].sq_dist;
			if (k > 0 && cell_entry[k].sq_dist < cell_entry[(k > 0) ? k - 1 : 0].sq_dist) begin
				sorted = 1'b0;
			end
		end
	end

	// The list is in ascending order whenever no dump is rotating it.
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		!dump_q |-> sorted)
		else $error("list out of order outside a dump");

	// An offer that does not beat the last entry leaves every distance alone.
	a_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd == npt_pkg::CMD_OFFER && !cell_gt[LIST_DEPTH-1]
		|=> $stable(dist_vec))
		else $error("rejected offer changed the list");

	// The final rotation step presents a flagged last beat and releases the request side.
	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		step && cnt_q == CNT_LAST |=> rsp.valid && rsp.is_last && !dump_q)
		else $error("dump did not end with a flagged beat");

	// An accepted dump raises the dump flag in the very next cycle.
	a_dump_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd == npt_pkg::CMD_DUMP |=> dump_q)
		else $error("accepted dump did not start rotating");

endmodule
